>>> src/assert_macros.svh
// Assertion helpers for the rate limiter block.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked check, masked while reset is asserted.
`define KRL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("krl: assertion failed");

// Clocked check that also holds across reset.
`define KRL_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("krl: assertion failed");

`else

`define KRL_ASSERT(lbl, clk, rst_n, prop)
`define KRL_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> src/krl_pkg.sv
package krl_pkg;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam int KEY_WIDTH_DEF   = 32;
  localparam int TIME_W          = 32;
  localparam int IN_KEY_W        = 32;
  localparam int ENTRY_IDX_W     = 5;
  localparam int CFG_DATA_W      = 32;
  localparam int CFG_ADDR_W      = 3;
  localparam int REG_IDX_W       = CFG_ADDR_W - 2;

  localparam logic [TIME_W-1:0]    RATE_LIMIT_RST = 32'd5000;
  localparam logic [REG_IDX_W-1:0] REG_RATE_LIMIT = '0;

  localparam logic FUNC_CHECK = 1'b0;
  localparam logic FUNC_RESET = 1'b1;

  typedef enum logic [2:0] {
    OUT_HIT_ALLOWED    = 3'd0,
    OUT_HIT_SUPPRESSED = 3'd1,
    OUT_INSERTED       = 3'd2,
    OUT_EVICTED        = 3'd3,
    OUT_RESET_DONE     = 3'd4,
    OUT_RESET_MISS     = 3'd5
  } outcome_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DIFF,
    ST_LIMIT,
    ST_OLDEST,
    ST_WRITE,
    ST_RESP
  } state_t;

  // Index width for a table of the given depth, never below one bit.
  function automatic int idx_width(input int depth);
    int w;
    w = (depth > 1) ? $clog2(depth) : 1;
    return w;
  endfunction

endpackage

>>> src/krl_apb_regs.sv
module krl_apb_regs import krl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [TIME_W-1:0]     min_gap_ms
);

  logic [TIME_W-1:0]    rate_limit_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_stb;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_stb  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_limit_r <= RATE_LIMIT_RST;
    end else if (wr_stb && (reg_idx == REG_RATE_LIMIT)) begin
      rate_limit_r <= pwdata[TIME_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_RATE_LIMIT) begin
      prdata = CFG_DATA_W'(rate_limit_r);
    end
  end

  assign min_gap_ms = rate_limit_r;

endmodule

>>> src/krl_table_mem.sv
module krl_table_mem import krl_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic [idx_width(TABLE_DEPTH)-1:0]  rd_addr,
  output logic [KEY_WIDTH-1:0]               rd_key,
  output logic [TIME_W-1:0]                  rd_time,
  input  logic                               wr_en,
  input  logic [idx_width(TABLE_DEPTH)-1:0]  wr_addr,
  input  logic [KEY_WIDTH-1:0]               wr_key,
  input  logic [TIME_W-1:0]                  wr_time
);

  logic [KEY_WIDTH-1:0] key_mem  [TABLE_DEPTH];
  logic [TIME_W-1:0]    time_mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]  <= wr_key;
      time_mem[wr_addr] <= wr_time;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_key  <= key_mem[rd_addr];
    rd_time <= time_mem[rd_addr];
  end

endmodule

>>> src/keyed_rate_limit_table.sv
// Channel   Direction  Handshake              Beat contents
// --------  ---------  ---------------------  -------------------------------
// in        input      in_valid / in_ready    in_func, in_key, in_now_ms
// out       output     out_valid / out_ready  out_allowed, out_entry_index,
//                                             out_outcome
// cfg       input      psel/penable, pready   minimum gap (ms) at paddr 0
//
// A request sweeps the filled entries for its key; an eviction then also sweeps them for
// the oldest entry. Each sweep reads one entry a cycle through the single registered read
// port of the table memory. rst_n is synchronous; it empties the table (fill count to zero)
// and sets the limit to 5000. in_ready is low from acceptance until the result beat sits in
// the output register.
`include "assert_macros.svh"

module keyed_rate_limit_table import krl_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]  prdata,
  output logic                   pready,
  // request channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_func,
  input  logic [IN_KEY_W-1:0]    in_key,
  input  logic [TIME_W-1:0]      in_now_ms,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_allowed,
  output logic [ENTRY_IDX_W-1:0] out_entry_index,
  output logic [2:0]             out_outcome
);

  localparam int IDX_W = idx_width(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  state_t                   state_r,       state_nxt;
  logic [CNT_W-1:0]         fill_r,        fill_nxt;
  logic [CNT_W-1:0]         rd_cnt_r,      rd_cnt_nxt;
  logic                     cmp_vld_r,     cmp_vld_nxt;
  logic                     out_valid_r,   out_valid_nxt;

  logic                     func_r,        func_nxt;
  logic [KEY_WIDTH-1:0]     key_r,         key_nxt;
  logic [TIME_W-1:0]        now_r,         now_nxt;
  logic [IDX_W-1:0]         cmp_idx_r,     cmp_idx_nxt;
  logic [IDX_W-1:0]         best_idx_r,    best_idx_nxt;
  logic [TIME_W-1:0]        best_time_r,   best_time_nxt;
  logic [TIME_W-1:0]        diff_r,        diff_nxt;
  logic [IDX_W-1:0]         res_idx_r,     res_idx_nxt;
  outcome_t                 res_outcome_r, res_outcome_nxt;
  logic                     res_allowed_r, res_allowed_nxt;
  logic                     out_allowed_r, out_allowed_nxt;
  logic [ENTRY_IDX_W-1:0]   out_idx_r,     out_idx_nxt;
  outcome_t                 out_outcome_r, out_outcome_nxt;

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic [TIME_W-1:0] min_gap_ms;

  krl_apb_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .min_gap_ms (min_gap_ms)
  );

  // ---------------------------------------------------------------------
  // Key and time store: one read port, swept by rd_cnt_r
  // ---------------------------------------------------------------------
  logic [KEY_WIDTH-1:0] rd_key;
  logic [TIME_W-1:0]    rd_time;
  logic                 wr_en;
  logic [TIME_W-1:0]    wr_time;

  // A reset request that hit writes a zero time; every other write records now.
  assign wr_time = (func_r == FUNC_RESET) ? '0 : now_r;

  krl_table_mem #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_mem (
    .clk     (clk),
    .rd_addr (rd_cnt_r[IDX_W-1:0]),
    .rd_key  (rd_key),
    .rd_time (rd_time),
    .wr_en   (wr_en),
    .wr_addr (res_idx_r),
    .wr_key  (key_r),
    .wr_time (wr_time)
  );

  // ---------------------------------------------------------------------
  // Shared subtractor: elapsed time, limit compare and oldest search all
  // go through this one 33-bit subtract; the top bit is the borrow (a < b).
  // ---------------------------------------------------------------------
  logic [TIME_W-1:0] unit_a;
  logic [TIME_W-1:0] unit_b;
  logic [TIME_W:0]   unit_res;
  logic              unit_borrow;

  always_comb begin
    case (state_r)
      ST_DIFF: begin
        unit_a = now_r;
        unit_b = best_time_r;
      end
      ST_LIMIT: begin
        unit_a = diff_r;
        unit_b = min_gap_ms;
      end
      default: begin
        unit_a = rd_time;
        unit_b = best_time_r;
      end
    endcase
  end

  assign unit_res    = {1'b0, unit_a} - {1'b0, unit_b};
  assign unit_borrow = unit_res[TIME_W];

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt       = state_r;
    fill_nxt        = fill_r;
    rd_cnt_nxt      = rd_cnt_r;
    cmp_vld_nxt     = cmp_vld_r;
    func_nxt        = func_r;
    key_nxt         = key_r;
    now_nxt         = now_r;
    cmp_idx_nxt     = cmp_idx_r;
    best_idx_nxt    = best_idx_r;
    best_time_nxt   = best_time_r;
    diff_nxt        = diff_r;
    res_idx_nxt     = res_idx_r;
    res_outcome_nxt = res_outcome_r;
    res_allowed_nxt = res_allowed_r;
    out_allowed_nxt = out_allowed_r;
    out_idx_nxt     = out_idx_r;
    out_outcome_nxt = out_outcome_r;
    wr_en           = 1'b0;

    // Drop the held result once it has been taken.
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      ST_IDLE: begin
        rd_cnt_nxt  = '0;
        cmp_vld_nxt = 1'b0;
        if (in_valid) begin
          func_nxt  = in_func;
          key_nxt   = KEY_WIDTH'(in_key);
          now_nxt   = in_now_ms;
          state_nxt = ST_LOOKUP;
        end
      end

      ST_LOOKUP: begin
        // Issue the next read; its data is compared in the following cycle.
        if (rd_cnt_r < fill_r) begin
          rd_cnt_nxt  = rd_cnt_r + 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_cnt_r[IDX_W-1:0];
        end else begin
          cmp_vld_nxt = 1'b0;
        end

        if (cmp_vld_r && (rd_key == key_r)) begin
          res_idx_nxt   = cmp_idx_r;
          best_time_nxt = rd_time;
          if (func_r == FUNC_RESET) begin
            res_outcome_nxt = OUT_RESET_DONE;
            res_allowed_nxt = 1'b0;
            state_nxt       = ST_WRITE;
          end else begin
            state_nxt = ST_DIFF;
          end
        end else if (!cmp_vld_r && (rd_cnt_r == fill_r)) begin
          // Every filled entry compared: miss.
          rd_cnt_nxt  = '0;
          cmp_vld_nxt = 1'b0;
          if (func_r == FUNC_RESET) begin
            res_idx_nxt     = '0;
            res_outcome_nxt = OUT_RESET_MISS;
            res_allowed_nxt = 1'b0;
            state_nxt       = ST_RESP;
          end else if (fill_r != FULL_CNT) begin
            res_idx_nxt     = fill_r[IDX_W-1:0];
            res_outcome_nxt = OUT_INSERTED;
            res_allowed_nxt = 1'b1;
            state_nxt       = ST_WRITE;
          end else begin
            state_nxt = ST_OLDEST;
          end
        end
      end

      ST_DIFF: begin
        diff_nxt  = unit_res[TIME_W-1:0];
        state_nxt = ST_LIMIT;
      end

      ST_LIMIT: begin
        if (!unit_borrow) begin
          res_outcome_nxt = OUT_HIT_ALLOWED;
          res_allowed_nxt = 1'b1;
          state_nxt       = ST_WRITE;
        end else begin
          res_outcome_nxt = OUT_HIT_SUPPRESSED;
          res_allowed_nxt = 1'b0;
          state_nxt       = ST_RESP;
        end
      end

      ST_OLDEST: begin
        if (rd_cnt_r < fill_r) begin
          rd_cnt_nxt  = rd_cnt_r + 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_cnt_r[IDX_W-1:0];
        end else begin
          cmp_vld_nxt = 1'b0;
        end

        // Strictly smaller only, so the lowest index keeps a tie.
        if (cmp_vld_r && ((cmp_idx_r == '0) || unit_borrow)) begin
          best_idx_nxt  = cmp_idx_r;
          best_time_nxt = rd_time;
        end

        if (!cmp_vld_r && (rd_cnt_r == fill_r)) begin
          res_idx_nxt     = best_idx_r;
          res_outcome_nxt = OUT_EVICTED;
          res_allowed_nxt = 1'b1;
          state_nxt       = ST_WRITE;
        end
      end

      ST_WRITE: begin
        wr_en = 1'b1;
        if (res_outcome_r == OUT_INSERTED) begin
          fill_nxt = fill_r + 1'b1;
        end
        state_nxt = ST_RESP;
      end

      ST_RESP: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_allowed_nxt = res_allowed_r;
          out_idx_nxt     = ENTRY_IDX_W'(res_idx_r);
          out_outcome_nxt = res_outcome_r;
          state_nxt       = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      rd_cnt_r    <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    func_r        <= func_nxt;
    key_r         <= key_nxt;
    now_r         <= now_nxt;
    cmp_idx_r     <= cmp_idx_nxt;
    best_idx_r    <= best_idx_nxt;
    best_time_r   <= best_time_nxt;
    diff_r        <= diff_nxt;
    res_idx_r     <= res_idx_nxt;
    res_outcome_r <= res_outcome_nxt;
    res_allowed_r <= res_allowed_nxt;
    out_allowed_r <= out_allowed_nxt;
    out_idx_r     <= out_idx_nxt;
    out_outcome_r <= out_outcome_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_allowed     = out_allowed_r;
  assign out_entry_index = out_idx_r;
  assign out_outcome     = out_outcome_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // Result beats that must never carry an allow.
  logic out_denied;
  assign out_denied = out_valid && ((out_outcome == OUT_RESET_DONE) ||
                                    (out_outcome == OUT_RESET_MISS) ||
                                    (out_outcome == OUT_HIT_SUPPRESSED));

  `KRL_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (state_r == ST_IDLE) && !out_valid_r)
  `KRL_ASSERT(a_fill_bound, clk, rst_n, fill_r <= FULL_CNT)
  `KRL_ASSERT(a_accept_lookup, clk, rst_n, (in_valid && in_ready) |=> (state_r == ST_LOOKUP))
  `KRL_ASSERT(a_load_from_resp, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == ST_RESP))
  `KRL_ASSERT(a_reset_not_allowed, clk, rst_n, out_denied |-> !out_allowed)

endmodule

>>> test/keyed_rate_limit_table_tb.sv
`timescale 1ns / 1ps

module keyed_rate_limit_table_tb;
  import krl_pkg::*;

  localparam int DEPTH            = TABLE_DEPTH_DEF;
  localparam int SEGMENTS         = 6;
  localparam int SEGMENT_ITEMS    = 175;
  localparam int POOL_SIZE        = 40;
  localparam int PRESSURE_SEGMENT = 4;
  localparam int HOLD_OFF_CYCLES  = 400;
  // Longest request is an eviction at a full table.
  localparam int DRAIN_CYCLES     = 80;
  localparam int DIRECTED_ROWS    = 20;

  // One result beat, field by field.
  typedef struct packed {
    logic                   allowed;
    logic [ENTRY_IDX_W-1:0] entry_index;
    outcome_t               outcome;
  } decision_t;

  // One request beat; typed rows carry the result that is plain from the rules.
  typedef struct packed {
    logic                func;
    logic [IN_KEY_W-1:0] key;
    logic [TIME_W-1:0]   now_ms;
    logic                typed;
    decision_t           want;
  } probe_row_t;

  localparam decision_t NO_WANT = '{1'b0, 5'd0, OUT_HIT_ALLOWED};

  // Directed opening, run at the reset limit of 5000 on an empty table.
  localparam probe_row_t PROBES [DIRECTED_ROWS] = '{
    // first insert: lowest key, zero time
    '{FUNC_CHECK, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b1, 5'd0, OUT_INSERTED}},
    // highest key, highest time
    '{FUNC_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b1, 5'd1, OUT_INSERTED}},
    // one short of the limit, then exactly on it
    '{FUNC_CHECK, 32'h0000_0000, 32'd4999, 1'b0, NO_WANT},
    '{FUNC_CHECK, 32'h0000_0000, 32'd5000, 1'b0, NO_WANT},
    // elapsed time wraps past zero
    '{FUNC_CHECK, 32'hFFFF_FFFF, 32'd4998, 1'b0, NO_WANT},
    '{FUNC_CHECK, 32'hFFFF_FFFF, 32'd4999, 1'b0, NO_WANT},
    // clear a timer, then miss on an unknown key
    '{FUNC_RESET, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 5'd0, OUT_RESET_DONE}},
    '{FUNC_RESET, 32'h1234_5678, 32'hFFFF_FFFF, 1'b1, '{1'b0, 5'd0, OUT_RESET_MISS}},
    // suppressed hits must leave the stored time alone
    '{FUNC_CHECK, 32'h0000_0000, 32'd5000, 1'b0, NO_WANT},
    '{FUNC_CHECK, 32'h0000_0000, 32'd5001, 1'b0, NO_WANT},
    '{FUNC_CHECK, 32'h0000_0000, 32'd9999, 1'b0, NO_WANT},
    '{FUNC_CHECK, 32'h0000_0000, 32'd10000, 1'b0, NO_WANT},
    '{FUNC_CHECK, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{1'b1, 5'd2, OUT_INSERTED}},
    '{FUNC_CHECK, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{1'b1, 5'd3, OUT_INSERTED}},
    '{FUNC_RESET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b0, 5'd1, OUT_RESET_DONE}},
    '{FUNC_CHECK, 32'hFFFF_FFFF, 32'd4999, 1'b0, NO_WANT},
    '{FUNC_RESET, 32'h8000_0000, 32'd12345, 1'b1, '{1'b0, 5'd2, OUT_RESET_DONE}},
    '{FUNC_CHECK, 32'h8000_0000, 32'h0000_0000, 1'b0, NO_WANT},
    '{FUNC_RESET, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, '{1'b0, 5'd0, OUT_RESET_MISS}},
    '{FUNC_CHECK, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, '{1'b1, 5'd4, OUT_INSERTED}}
  };

  // Every input starts at a known value.
  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   psel      = 1'b0;
  logic                   penable   = 1'b0;
  logic                   pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0]  paddr     = '0;
  logic [CFG_DATA_W-1:0]  pwdata    = '0;
  logic [CFG_DATA_W-1:0]  prdata;
  logic                   pready;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  logic                   in_func   = FUNC_CHECK;
  logic [IN_KEY_W-1:0]    in_key    = '0;
  logic [TIME_W-1:0]      in_now_ms = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   out_allowed;
  logic [ENTRY_IDX_W-1:0] out_entry_index;
  logic [2:0]             out_outcome;

  // Mirror of the table, the fill count and the limit register.
  logic [IN_KEY_W-1:0] tracked_keys  [DEPTH];
  logic [TIME_W-1:0]   tracked_times [DEPTH];
  int unsigned         tracked_fill;
  logic [TIME_W-1:0]   tracked_limit;

  decision_t   decisions_due [$];
  int          fail_count    = 0;
  int          beats_seen    = 0;
  int          requests_sent = 0;
  int          tally [6]     = '{default: 0};
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          hold_off_at   = 32'h7FFF_FFFF;
  bit          held_off      = 1'b0;

  keyed_rate_limit_table DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_key          (in_key),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_allowed     (out_allowed),
    .out_entry_index (out_entry_index),
    .out_outcome     (out_outcome)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  // Work out the result of one request and advance the mirrored table.
  function automatic decision_t rate_decide(input logic func,
                                            input logic [IN_KEY_W-1:0] key,
                                            input logic [TIME_W-1:0] now);
    decision_t         d;
    int                hit;
    int                i;
    int unsigned       pick;
    logic [TIME_W-1:0] elapsed;
    d   = '{1'b0, 5'd0, OUT_RESET_MISS};
    hit = -1;
    // Only filled entries take part in the search; first match wins.
    for (i = 0; i < int'(tracked_fill); i++) begin
      if (hit < 0 && tracked_keys[i] == key) hit = i;
    end
    if (func == FUNC_RESET) begin
      // A miss leaves the table alone and reports entry zero.
      if (hit >= 0) begin
        tracked_times[hit] = '0;
        d.entry_index      = hit[ENTRY_IDX_W-1:0];
        d.outcome          = OUT_RESET_DONE;
      end
    end else if (hit >= 0) begin
      d.entry_index = hit[ENTRY_IDX_W-1:0];
      elapsed       = now - tracked_times[hit];
      if (elapsed >= tracked_limit) begin
        tracked_times[hit] = now;
        d.allowed          = 1'b1;
        d.outcome          = OUT_HIT_ALLOWED;
      end else begin
        d.outcome = OUT_HIT_SUPPRESSED;
      end
    end else begin
      if (tracked_fill < DEPTH) begin
        pick = tracked_fill;
        tracked_fill++;
        d.outcome = OUT_INSERTED;
      end else begin
        // Replace the oldest stored time; strict compare keeps the lowest index on ties.
        pick = 0;
        for (i = 1; i < DEPTH; i++) begin
          if (tracked_times[i] < tracked_times[pick]) pick = i;
        end
        d.outcome = OUT_EVICTED;
      end
      tracked_keys[pick]  = key;
      tracked_times[pick] = now;
      d.allowed           = 1'b1;
      d.entry_index       = pick[ENTRY_IDX_W-1:0];
    end
    return d;
  endfunction

  // Present one request beat, hold it until accepted, then log its expected result.
  // Entered and left at a rising edge; in_valid gets at most one update per edge.
  task automatic offer_request(input probe_row_t row);
    int        gap;
    decision_t guess;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_func   <= row.func;
    in_key    <= row.key;
    in_now_ms <= row.now_ms;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    guess = rate_decide(row.func, row.key, row.now_ms);
    decisions_due.push_back(row.typed ? row.want : guess);
    requests_sent++;
  endtask

  // Write the limit register, then read it straight back in a second transfer.
  task automatic program_limit(input logic [TIME_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_RATE_LIMIT, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracked_limit = value;
    // Keep psel high and drop into the setup phase of the read.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== value) begin
      $error("min_gap_ms readback: expected %0h, got %0h", value, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Compare one result beat with the oldest pending decision.
  task automatic check_beat(input decision_t got);
    decision_t want;
    if (decisions_due.size() == 0) begin
      $error("result beat with nothing pending: allowed %0d, entry_index %0d, outcome %0d",
             got.allowed, got.entry_index, got.outcome);
      fail_count++;
    end else begin
      want = decisions_due.pop_front();
      if (got.allowed !== want.allowed) begin
        $error("allowed: expected %0d, got %0d", want.allowed, got.allowed);
        fail_count++;
      end
      if (got.entry_index !== want.entry_index) begin
        $error("entry_index: expected %0d, got %0d", want.entry_index, got.entry_index);
        fail_count++;
      end
      if (got.outcome !== want.outcome) begin
        $error("outcome: expected %0d, got %0d", want.outcome, got.outcome);
        fail_count++;
      end
    end
  endtask

  // Result side: take beats, check them, and stall at random. Once, hold off for a
  // long stretch so the output register fills and in_ready drops while requests wait.
  initial begin : result_side
    decision_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.allowed     = out_allowed;
        got.entry_index = out_entry_index;
        got.outcome     = outcome_t'(out_outcome);
        check_beat(got);
        beats_seen++;
        if (int'(got.outcome) < 6) tally[int'(got.outcome)]++;
      end
      if (!held_off && beats_seen >= hold_off_at) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Request side: reset, directed table, then random segments under changing limits.
  initial begin : stimulus
    probe_row_t          row;
    logic [TIME_W-1:0]   wall_ms;
    logic [TIME_W-1:0]   step_span;
    logic [TIME_W-1:0]   limit_now;
    logic [IN_KEY_W-1:0] key_pool [POOL_SIZE];
    int                  seg;
    int                  n;
    int unsigned         roll;
    tracked_fill  = 0;
    tracked_limit = RATE_LIMIT_RST;
    for (n = 0; n < POOL_SIZE; n++) key_pool[n] = $urandom;
    wall_ms = $urandom;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows rely on the reset value of the limit.
    send_idle_pct = 29;
    recv_idle_pct = 80;
    for (n = 0; n < DIRECTED_ROWS; n++) offer_request(PROBES[n]);

    for (seg = 0; seg < SEGMENTS; seg++) begin
      // Drain before touching the register: the block must be idle.
      in_valid <= 1'b0;
      while (decisions_due.size() != 0) @(posedge clk);

      case (seg)
        0:       limit_now = '0;
        1:       limit_now = '1;
        2:       limit_now = $urandom_range(4000, 1);
        3:       limit_now = RATE_LIMIT_RST;
        4:       limit_now = $urandom;
        default: limit_now = $urandom_range(2000, 1);
      endcase
      program_limit(limit_now);

      // Sender-light then receiver-light idling, then none at all.
      if (seg < 2) begin
        send_idle_pct = 29;
        recv_idle_pct = 80;
      end else if (seg < 4) begin
        send_idle_pct = 80;
        recv_idle_pct = 29;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (seg == PRESSURE_SEGMENT) hold_off_at = beats_seen + 8;

      // Scale the clock step so a key revisited from the pool straddles the limit.
      step_span = (limit_now >> 4) + 1;
      for (n = 0; n < POOL_SIZE; n++) begin
        if ($urandom_range(1) == 0) key_pool[n] = $urandom;
      end

      for (n = 0; n < SEGMENT_ITEMS; n++) begin
        roll = $urandom_range(99);
        // Mostly advance, sometimes hold, jump anywhere, or step back.
        if (roll >= 95) begin
          wall_ms = wall_ms - $urandom_range(3000, 1);
        end else if (roll >= 85) begin
          wall_ms = $urandom;
        end else if (roll >= 10) begin
          wall_ms = wall_ms + $urandom_range(step_span, 1);
        end
        row.func   = ($urandom_range(99) < 15) ? FUNC_RESET : FUNC_CHECK;
        row.key    = ($urandom_range(9) == 0) ? $urandom
                                              : key_pool[$urandom_range(POOL_SIZE - 1)];
        row.now_ms = wall_ms;
        row.typed  = 1'b0;
        row.want   = NO_WANT;
        offer_request(row);
      end
    end

    in_valid <= 1'b0;
    while (decisions_due.size() != 0) @(posedge clk);
    // Allow for a late stray beat after the last expected one.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d requests under limits of zero, all ones, 5000 and random values",
             requests_sent);
    $display("outcomes: %0d allowed hits, %0d suppressed, %0d inserts, %0d evictions,",
             tally[0], tally[1], tally[2], tally[3], " %0d resets, %0d reset misses",
             tally[4], tally[5]);
    if (fail_count == 0 && decisions_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
